/* src/bounded_value_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded value list engine
// Shared property shapes, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_VALUE_LIST_ENGINE_MACROS_SVH
`define BOUNDED_VALUE_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BVLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BVLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bvle_pkg.sv */
// ----------------------------------------------------------------------------
// bvle_pkg
// Types, codes and sizes shared by the bounded value list engine.
// ----------------------------------------------------------------------------
package bvle_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int VAL_W           = 32;

  // Command codes
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_SWAP   = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_SWAP_FIND,
    S_SWAP_WRITE,
    S_READ,
    S_REPLY
  } state_t;

  // Per-cycle operation broadcast along the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROT,
    CELL_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] fill_value;
  } chain_ctl_t;

endpackage

/* src/bvle_cell.sv */
// ----------------------------------------------------------------------------
// bvle_cell
// One list position: holds an entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
module bvle_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                             clk,
  input  bvle_pkg::chain_ctl_t             ctl,
  input  logic [CNT_W-1:0]                 len,
  input  logic signed [bvle_pkg::VAL_W-1:0] left_val,
  input  logic signed [bvle_pkg::VAL_W-1:0] right_val,
  output logic signed [bvle_pkg::VAL_W-1:0] val
);

  localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

  logic signed [bvle_pkg::VAL_W-1:0] val_r;
  logic signed [bvle_pkg::VAL_W-1:0] val_nxt;
  logic                              take_right;
  logic                              at_tail;

  assign take_right = (IDX_P1 < len);
  assign at_tail    = (IDX_P1 == len);

  // Pick the next entry from the neighbors or the broadcast fill value
  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      bvle_pkg::CELL_PUSH: begin
        val_nxt = (INDEX == 0) ? ctl.fill_value : left_val;
      end
      bvle_pkg::CELL_ROT: begin
        if (take_right) begin
          val_nxt = right_val;
        end else if (at_tail) begin
          val_nxt = ctl.fill_value;
        end
      end
      bvle_pkg::CELL_DROP: begin
        if (take_right) begin
          val_nxt = right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* src/bvle_ctrl.sv */
// ----------------------------------------------------------------------------
// bvle_ctrl
// Command sequencer: accepts commands, steers the cell chain one head
// examination per cycle unless a read-out stalls, and drives the result register.
// ----------------------------------------------------------------------------
module bvle_ctrl #(
  parameter int MAX_ENTRIES = bvle_pkg::MAX_ENTRIES_DEF,
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bvle_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bvle_pkg::out_item_t               out_data,
  input  logic signed [bvle_pkg::VAL_W-1:0] head_val,
  output bvle_pkg::chain_ctl_t              chain_ctl,
  output logic [CNT_W-1:0]                  len
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  bvle_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [CNT_W-1:0]                  total_r, total_nxt;
  logic [CNT_W-1:0]                  step_r, step_nxt;
  logic [CNT_W-1:0]                  ia_r, ia_nxt;
  logic [CNT_W-1:0]                  ib_r, ib_nxt;
  logic signed [bvle_pkg::VAL_W-1:0] a_r, a_nxt;
  logic signed [bvle_pkg::VAL_W-1:0] b_r, b_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic                              found_r, found_nxt;
  logic                              fa_r, fa_nxt;
  logic                              fb_r, fb_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bvle_pkg::out_item_t               out_data_r, out_data_nxt;

  logic in_fire;
  logic out_free;
  logic last_step;
  logic hit_a;
  logic hit_b;

  assign in_ready  = (state_r == bvle_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == total_r - ONE);
  assign hit_a     = (head_val == a_r);
  assign hit_b     = (head_val == b_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bvle_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_data.kind)
            bvle_pkg::KIND_REMOVE: begin
              state_nxt = (count_r == '0) ? bvle_pkg::S_REPLY : bvle_pkg::S_REMOVE;
            end
            bvle_pkg::KIND_SWAP: begin
              state_nxt = (count_r == '0) ? bvle_pkg::S_REPLY : bvle_pkg::S_SWAP_FIND;
            end
            bvle_pkg::KIND_READ: begin
              state_nxt = (count_r == '0) ? bvle_pkg::S_REPLY : bvle_pkg::S_READ;
            end
            default: begin
              state_nxt = bvle_pkg::S_REPLY;
            end
          endcase
        end
      end
      bvle_pkg::S_REMOVE: begin
        if (last_step) begin
          state_nxt = bvle_pkg::S_REPLY;
        end
      end
      bvle_pkg::S_SWAP_FIND: begin
        if (last_step) begin
          if ((fa_r || hit_a) && (fb_r || (!hit_a && hit_b))) begin
            state_nxt = bvle_pkg::S_SWAP_WRITE;
          end else begin
            state_nxt = bvle_pkg::S_REPLY;
          end
        end
      end
      bvle_pkg::S_SWAP_WRITE: begin
        if (last_step) begin
          state_nxt = bvle_pkg::S_REPLY;
        end
      end
      bvle_pkg::S_READ: begin
        if (out_free && last_step) begin
          state_nxt = bvle_pkg::S_IDLE;
        end
      end
      bvle_pkg::S_REPLY: begin
        if (out_free) begin
          state_nxt = bvle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bvle_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, chain steering and result register
  always_comb begin
    count_nxt            = count_r;
    total_nxt            = total_r;
    step_nxt             = step_r;
    ia_nxt               = ia_r;
    ib_nxt               = ib_r;
    a_nxt                = a_r;
    b_nxt                = b_r;
    status_nxt           = status_r;
    found_nxt            = found_r;
    fa_nxt               = fa_r;
    fb_nxt               = fb_r;
    out_valid_nxt        = out_valid_r && !out_ready;
    out_data_nxt         = out_data_r;
    chain_ctl.op         = bvle_pkg::CELL_HOLD;
    chain_ctl.fill_value = head_val;

    unique case (state_r)
      bvle_pkg::S_IDLE: begin
        if (in_fire) begin
          a_nxt      = in_data.value_a;
          b_nxt      = in_data.value_b;
          step_nxt   = '0;
          total_nxt  = count_r;
          found_nxt  = 1'b0;
          fa_nxt     = 1'b0;
          fb_nxt     = 1'b0;
          status_nxt = bvle_pkg::STAT_OK;
          case (in_data.kind)
            bvle_pkg::KIND_INSERT: begin
              if (count_r < MAX_CNT) begin
                chain_ctl.op         = bvle_pkg::CELL_PUSH;
                chain_ctl.fill_value = in_data.value_a;
                count_nxt            = count_r + ONE;
              end else begin
                status_nxt = bvle_pkg::STAT_FULL;
              end
            end
            bvle_pkg::KIND_REMOVE: begin
              status_nxt = (count_r == '0) ? bvle_pkg::STAT_EMPTY : bvle_pkg::STAT_NOT_FOUND;
            end
            bvle_pkg::KIND_SWAP: begin
              status_nxt = bvle_pkg::STAT_NOT_FOUND;
            end
            bvle_pkg::KIND_READ: begin
              status_nxt = (count_r == '0) ? bvle_pkg::STAT_EMPTY : bvle_pkg::STAT_OK;
            end
            bvle_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              status_nxt = bvle_pkg::STAT_OK;
            end
          endcase
        end
      end
      bvle_pkg::S_REMOVE: begin
        // Drop the first match at the head, recycle everything else
        if (hit_a && !found_r) begin
          chain_ctl.op = bvle_pkg::CELL_DROP;
          count_nxt    = count_r - ONE;
          found_nxt    = 1'b1;
          status_nxt   = bvle_pkg::STAT_OK;
        end else begin
          chain_ctl.op = bvle_pkg::CELL_ROT;
        end
        step_nxt = step_r + ONE;
      end
      bvle_pkg::S_SWAP_FIND: begin
        // Full rotation; remember the last position of each value
        chain_ctl.op = bvle_pkg::CELL_ROT;
        if (hit_a) begin
          fa_nxt = 1'b1;
          ia_nxt = step_r;
        end else if (hit_b) begin
          fb_nxt = 1'b1;
          ib_nxt = step_r;
        end
        step_nxt = last_step ? '0 : step_r + ONE;
      end
      bvle_pkg::S_SWAP_WRITE: begin
        // Second rotation writes the exchanged values back at the tail
        chain_ctl.op = bvle_pkg::CELL_ROT;
        if (step_r == ia_r) begin
          chain_ctl.fill_value = b_r;
        end else if (step_r == ib_r) begin
          chain_ctl.fill_value = a_r;
        end
        if (last_step) begin
          status_nxt = bvle_pkg::STAT_OK;
        end
        step_nxt = step_r + ONE;
      end
      bvle_pkg::S_READ: begin
        // Hand out the head and rotate once per transfer
        if (out_free) begin
          chain_ctl.op             = bvle_pkg::CELL_ROT;
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = bvle_pkg::STAT_OK;
          out_data_nxt.entry_value = head_val;
          out_data_nxt.last        = last_step;
          step_nxt                 = step_r + ONE;
        end
      end
      bvle_pkg::S_REPLY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_value = '0;
          out_data_nxt.last        = 1'b1;
        end
      end
      default: begin
        chain_ctl.op = bvle_pkg::CELL_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bvle_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
    end
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    step_r     <= step_nxt;
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign len       = count_r;

endmodule

/* src/bounded_value_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_value_list_engine
// Bounded list of signed 32-bit values, newest first, held in a cell chain.
// ----------------------------------------------------------------------------
// The list lives in a row of MAX_ENTRIES cells, cell 0 holding the front, and
// the controller looks only at the head cell: every walk over the list
// rotates the chain by one position per cycle. Insert, clear and unknown
// commands need no walk, remove walks the list once, swap walks it twice
// when both values are present (once otherwise), and read-out gives one entry
// per cycle, pausing while the result side stalls. One command is in flight
// at a time; in_ready is high only while the controller is idle.
module bounded_value_list_engine #(
  parameter int MAX_ENTRIES = bvle_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bvle_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  bvle_pkg::chain_ctl_t              chain_ctl;
  logic [CNT_W-1:0]                  len;
  logic signed [bvle_pkg::VAL_W-1:0] cell_val [MAX_ENTRIES];

  bvle_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head_val  (cell_val[0]),
    .chain_ctl (chain_ctl),
    .len       (len)
  );

  // Build the chain; the ends see zero past the edge
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [bvle_pkg::VAL_W-1:0] left_val;
    logic signed [bvle_pkg::VAL_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end

    bvle_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (chain_ctl),
      .len       (len),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g])
    );
  end

endmodule

/* src/bvle_checker.sv */
// ----------------------------------------------------------------------------
// bvle_checker
// Port-level checks for the bounded value list engine, bound to the top.
// ----------------------------------------------------------------------------
`include "bounded_value_list_engine_macros.svh"

module bvle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bvle_pkg::out_item_t out_data
);

  // Hold a stalled result
  `BVLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Stay busy right after taking a command
  `BVLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after a transfer")

  // Carry zero in the value of every non-ok result
  `BVLE_ASSERT_SAME(a_value_zero, out_valid && (out_data.status != bvle_pkg::STAT_OK), out_data.entry_value == 32'sd0, "nonzero value on a failed result")

  // Keep input closed while a read-out is still running
  `BVLE_ASSERT_SAME(a_readout_busy, out_valid && !out_data.last, !in_ready && (out_data.status == bvle_pkg::STAT_OK), "read-out entry not ok or input open")

endmodule

bind bounded_value_list_engine bvle_checker u_bvle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
